>>> design/lhkc_pkg.sv
// Shared types and constants of the LRU hash key cache.
`default_nettype none
package lhkc_pkg;

  localparam int ID_COUNT        = 512;
  localparam int ID_W            = 9;
  localparam int LINK_W          = 10;
  localparam int KEY_W           = 64;
  localparam int STATUS_W        = 3;
  localparam int HELD_W          = 10;
  localparam int OUT_W           = 96;
  localparam int DEF_SLOT_COUNT  = 1024;
  localparam int DEF_EVICT_LIMIT = 511;

  localparam logic [LINK_W-1:0] NO_ID = 10'd512;

  localparam logic [STATUS_W-1:0] STAT_HIT    = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_INS    = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_EVICT  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_REM    = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_ABSENT = 3'd4;

  typedef enum logic [1:0] {
    KIND_LOOKUP,
    KIND_REMOVE,
    KIND_IGNORE
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [KEY_W-1:0] key;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

  typedef struct packed {
    logic init_done;
    logic pop;
  } back_stat_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_HOME,
    ST_F_RD,
    ST_F_CHK,
    ST_F_KEY,
    ST_MISS,
    ST_V_KEY,
    ST_U_RD,
    ST_U_WR,
    ST_L_ONE,
    ST_L_TWO,
    ST_C_RD,
    ST_C_CHK,
    ST_R_RD,
    ST_R_ID,
    ST_R_KEY,
    ST_P_RD,
    ST_P_CHK,
    ST_D_END,
    ST_ALLOC,
    ST_A_POP,
    ST_A_KEY,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

>>> design/lhkc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lhkc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> design/lhkc_front.sv
// Front end: accepts input words, classifies them and queues them.
`default_nettype none
module lhkc_front (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [63:0]             s_tdata,
  input  wire logic                    s_tuser,
  input  wire lhkc_pkg::back_stat_t    bst,
  output lhkc_pkg::queue_t             q
);

  lhkc_pkg::item_t ent [2];
  lhkc_pkg::item_t in_item;
  logic            wp;
  logic            rp;
  logic [1:0]      cnt;
  logic            push;

  always_comb begin
    in_item.key = s_tdata;
    if (!s_tuser) begin
      in_item.kind = lhkc_pkg::KIND_LOOKUP;
    end else if (s_tdata == 64'd0) begin
      in_item.kind = lhkc_pkg::KIND_IGNORE;
    end else begin
      in_item.kind = lhkc_pkg::KIND_REMOVE;
    end
  end

  assign s_tready = (cnt != 2'd2) && bst.init_done;
  assign push     = s_tvalid && s_tready;
  assign q        = {(cnt != 2'd0), ent[rp]};

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (bst.pop) begin
        rp <= ~rp;
      end
      case ({push, bst.pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/lhkc_back.sv
// Back end: probes the slot table, maintains the LRU list and emits results.
`default_nettype none
module lhkc_back #(
  parameter int SLOT_COUNT  = lhkc_pkg::DEF_SLOT_COUNT,
  parameter int EVICT_LIMIT = lhkc_pkg::DEF_EVICT_LIMIT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire lhkc_pkg::queue_t           q,
  output lhkc_pkg::back_stat_t            bst,
  input  wire logic                       no_cache,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [lhkc_pkg::OUT_W-1:0]      m_tdata
);

  localparam int SW   = $clog2(SLOT_COUNT);
  localparam bit POW2 = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;
  localparam int CAP  = (SLOT_COUNT - 1 < lhkc_pkg::ID_COUNT) ? SLOT_COUNT - 1
                                                               : lhkc_pkg::ID_COUNT;

  lhkc_pkg::state_t st, st_next, ret;

  logic [63:0] cur_key;
  logic        op_rm;
  logic [SW-1:0] khome, h, h_inc;
  logic [8:0]  id, sid, pid;
  logic        drop_mode, evicting, inserting, new_place;
  logic [9:0]  gi, gj;
  logic [63:0] hk;
  logic [SW-1:0] hr;
  logic [5:0]  hcnt;
  logic [SW+3:0] hsh, hsub;
  logic        home_done;
  logic [SW:0] ic;
  logic [9:0]  count, fresh, freed, head, tail;
  logic [2:0]  r_status;
  logic [8:0]  r_eid, r_evid;
  logic [63:0] r_ekey;
  logic        r_clr;
  logic        ob_valid;
  logic [lhkc_pkg::OUT_W-1:0] ob_data;
  logic        have_free, evict_cond, ob_load, key_match;
  logic [9:0]  s_minus;

  logic          slot_we;
  logic [SW-1:0] slot_waddr, slot_raddr;
  logic [9:0]    slot_wdata, slot_rdata;
  logic          key_we;
  logic [8:0]    key_waddr, key_raddr;
  logic [63:0]   key_rdata;
  logic          prev_we, next_we;
  logic [8:0]    prev_waddr, next_waddr, link_raddr;
  logic [9:0]    prev_wdata, next_wdata, prev_rdata, next_rdata;
  logic          gat_we;
  logic [8:0]    gat_waddr, gat_raddr, gat_wdata, gat_rdata;
  logic          stk_we;
  logic [8:0]    stk_waddr, stk_raddr, stk_rdata;

  lhkc_ram #(.WIDTH(10), .DEPTH(SLOT_COUNT)) u_slot (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );
  lhkc_ram #(.WIDTH(64), .DEPTH(lhkc_pkg::ID_COUNT)) u_key (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(cur_key),
    .raddr(key_raddr), .rdata(key_rdata)
  );
  lhkc_ram #(.WIDTH(10), .DEPTH(lhkc_pkg::ID_COUNT)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(link_raddr), .rdata(prev_rdata)
  );
  lhkc_ram #(.WIDTH(10), .DEPTH(lhkc_pkg::ID_COUNT)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(link_raddr), .rdata(next_rdata)
  );
  lhkc_ram #(.WIDTH(9), .DEPTH(lhkc_pkg::ID_COUNT)) u_gather (
    .clk(clk), .we(gat_we), .waddr(gat_waddr), .wdata(gat_wdata),
    .raddr(gat_raddr), .rdata(gat_rdata)
  );
  lhkc_ram #(.WIDTH(9), .DEPTH(lhkc_pkg::ID_COUNT)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(id),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  assign h_inc      = (h == SW'(SLOT_COUNT - 1)) ? '0 : h + 1'b1;
  assign hsh        = {hr, hk[63:60]};
  assign home_done  = POW2 || (hcnt == 6'd15);
  assign have_free  = !((freed == 10'd0) && (fresh == 10'(lhkc_pkg::ID_COUNT)));
  assign evict_cond = ((16'(count) > 16'(EVICT_LIMIT)) || (count >= 10'(CAP)) ||
                       !have_free) && !tail[9];
  assign s_minus    = slot_rdata - 10'd1;
  assign key_match  = (key_rdata == cur_key);
  assign ob_load    = (st == lhkc_pkg::ST_OUT) && (!ob_valid || m_tready);

  assign bst      = {(st != lhkc_pkg::ST_INIT), ((st == lhkc_pkg::ST_IDLE) && q.valid)};
  assign m_tvalid = ob_valid;
  assign m_tdata  = ob_data;

  // reduce one key nibble per cycle against the multiples of SLOT_COUNT
  always_comb begin
    hsub = hsh;
    for (int k = 1; k < 16; k++) begin
      if (hsh >= (SW+4)'(k * SLOT_COUNT)) begin
        hsub = hsh - (SW+4)'(k * SLOT_COUNT);
      end
    end
  end

  always_comb begin
    st_next    = st;
    slot_we    = 1'b0;
    slot_waddr = h;
    slot_wdata = 10'd0;
    slot_raddr = h;
    key_we     = 1'b0;
    key_waddr  = id;
    key_raddr  = s_minus[8:0];
    prev_we    = 1'b0;
    prev_waddr = id;
    prev_wdata = lhkc_pkg::NO_ID;
    next_we    = 1'b0;
    next_waddr = id;
    next_wdata = head;
    link_raddr = id;
    gat_we     = 1'b0;
    gat_waddr  = gj[8:0];
    gat_wdata  = s_minus[8:0];
    gat_raddr  = gi[8:0];
    stk_we     = 1'b0;
    stk_waddr  = freed[8:0];
    stk_raddr  = 9'(freed - 10'd1);
    case (st)
      lhkc_pkg::ST_INIT: begin
        slot_we    = 1'b1;
        slot_waddr = ic[SW-1:0];
        if (ic == (SW+1)'(SLOT_COUNT - 1)) begin
          st_next = lhkc_pkg::ST_IDLE;
        end
      end
      lhkc_pkg::ST_IDLE: begin
        if (q.valid) begin
          st_next = (q.item.kind == lhkc_pkg::KIND_IGNORE) ? lhkc_pkg::ST_OUT
                                                           : lhkc_pkg::ST_HOME;
        end
      end
      lhkc_pkg::ST_HOME: begin
        if (home_done) begin
          st_next = ret;
        end
      end
      lhkc_pkg::ST_F_RD: st_next = lhkc_pkg::ST_F_CHK;
      lhkc_pkg::ST_F_CHK: begin
        if (slot_rdata == 10'd0) begin
          st_next = op_rm ? lhkc_pkg::ST_OUT : lhkc_pkg::ST_MISS;
        end else begin
          st_next = lhkc_pkg::ST_F_KEY;
        end
      end
      lhkc_pkg::ST_F_KEY: st_next = key_match ? lhkc_pkg::ST_U_RD : lhkc_pkg::ST_F_RD;
      lhkc_pkg::ST_MISS: begin
        key_raddr = tail[8:0];
        st_next   = evict_cond ? lhkc_pkg::ST_V_KEY : lhkc_pkg::ST_ALLOC;
      end
      lhkc_pkg::ST_V_KEY: st_next = lhkc_pkg::ST_HOME;
      lhkc_pkg::ST_U_RD:  st_next = lhkc_pkg::ST_U_WR;
      lhkc_pkg::ST_U_WR: begin
        next_we    = !prev_rdata[9];
        next_waddr = prev_rdata[8:0];
        next_wdata = next_rdata;
        prev_we    = !next_rdata[9];
        prev_waddr = next_rdata[8:0];
        prev_wdata = prev_rdata;
        st_next    = drop_mode ? lhkc_pkg::ST_C_RD : lhkc_pkg::ST_L_ONE;
      end
      lhkc_pkg::ST_L_ONE: begin
        prev_we = 1'b1;
        next_we = 1'b1;
        st_next = lhkc_pkg::ST_L_TWO;
      end
      lhkc_pkg::ST_L_TWO: begin
        prev_we    = !head[9];
        prev_waddr = head[8:0];
        prev_wdata = {1'b0, id};
        st_next    = inserting ? lhkc_pkg::ST_P_RD : lhkc_pkg::ST_OUT;
      end
      lhkc_pkg::ST_C_RD: st_next = lhkc_pkg::ST_C_CHK;
      lhkc_pkg::ST_C_CHK: begin
        if (slot_rdata == 10'd0) begin
          st_next = lhkc_pkg::ST_R_RD;
        end else begin
          gat_we  = (s_minus[8:0] != id);
          slot_we = 1'b1;
          st_next = lhkc_pkg::ST_C_RD;
        end
      end
      lhkc_pkg::ST_R_RD: st_next = (gi == gj) ? lhkc_pkg::ST_D_END : lhkc_pkg::ST_R_ID;
      lhkc_pkg::ST_R_ID: begin
        key_raddr = gat_rdata;
        st_next   = lhkc_pkg::ST_R_KEY;
      end
      lhkc_pkg::ST_R_KEY: st_next = lhkc_pkg::ST_HOME;
      lhkc_pkg::ST_P_RD:  st_next = lhkc_pkg::ST_P_CHK;
      lhkc_pkg::ST_P_CHK: begin
        if (slot_rdata == 10'd0) begin
          slot_we    = 1'b1;
          slot_wdata = {1'b0, pid} + 10'd1;
          st_next    = new_place ? lhkc_pkg::ST_OUT : lhkc_pkg::ST_R_RD;
        end else begin
          st_next = lhkc_pkg::ST_P_RD;
        end
      end
      lhkc_pkg::ST_D_END: begin
        stk_we  = !freed[9];
        st_next = evicting ? lhkc_pkg::ST_ALLOC : lhkc_pkg::ST_OUT;
      end
      lhkc_pkg::ST_ALLOC: begin
        if (!have_free) begin
          st_next = lhkc_pkg::ST_OUT;
        end else if (freed != 10'd0) begin
          st_next = lhkc_pkg::ST_A_POP;
        end else begin
          st_next = lhkc_pkg::ST_A_KEY;
        end
      end
      lhkc_pkg::ST_A_POP: st_next = lhkc_pkg::ST_A_KEY;
      lhkc_pkg::ST_A_KEY: begin
        key_we  = 1'b1;
        st_next = lhkc_pkg::ST_L_ONE;
      end
      lhkc_pkg::ST_OUT: begin
        if (!ob_valid || m_tready) begin
          st_next = lhkc_pkg::ST_IDLE;
        end
      end
      default: st_next = lhkc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= lhkc_pkg::ST_INIT;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ic    <= '0;
      count <= 10'd0;
      fresh <= 10'd0;
      freed <= 10'd0;
      head  <= lhkc_pkg::NO_ID;
      tail  <= lhkc_pkg::NO_ID;
    end else begin
      case (st)
        lhkc_pkg::ST_INIT: ic <= ic + 1'b1;
        lhkc_pkg::ST_IDLE: begin
          cur_key   <= q.item.key;
          op_rm     <= (q.item.kind == lhkc_pkg::KIND_REMOVE);
          hk        <= q.item.key;
          hr        <= '0;
          hcnt      <= 6'd0;
          ret       <= lhkc_pkg::ST_F_RD;
          evicting  <= 1'b0;
          inserting <= 1'b0;
          new_place <= 1'b0;
          r_status  <= lhkc_pkg::STAT_ABSENT;
          r_eid     <= 9'd0;
          r_evid    <= 9'd0;
          r_ekey    <= 64'd0;
          r_clr     <= 1'b0;
        end
        lhkc_pkg::ST_HOME: begin
          if (POW2) begin
            h <= hk[SW-1:0];
            if (ret == lhkc_pkg::ST_F_RD) begin
              khome <= hk[SW-1:0];
            end
          end else begin
            hk   <= {hk[59:0], 4'b0};
            hr   <= hsub[SW-1:0];
            hcnt <= hcnt + 6'd1;
            if (home_done) begin
              h <= hsub[SW-1:0];
              if (ret == lhkc_pkg::ST_F_RD) begin
                khome <= hsub[SW-1:0];
              end
            end
          end
        end
        lhkc_pkg::ST_F_CHK: sid <= s_minus[8:0];
        lhkc_pkg::ST_F_KEY: begin
          if (key_match) begin
            id    <= sid;
            r_eid <= sid;
            gj    <= 10'd0;
            h     <= khome;
            if (op_rm) begin
              r_status  <= lhkc_pkg::STAT_REM;
              drop_mode <= 1'b1;
            end else begin
              r_status  <= lhkc_pkg::STAT_HIT;
              r_clr     <= no_cache;
              drop_mode <= 1'b0;
            end
          end else begin
            h <= h_inc;
          end
        end
        lhkc_pkg::ST_MISS: begin
          if (evict_cond) begin
            id <= tail[8:0];
          end
        end
        lhkc_pkg::ST_V_KEY: begin
          r_ekey    <= key_rdata;
          r_evid    <= id;
          evicting  <= 1'b1;
          drop_mode <= 1'b1;
          gj        <= 10'd0;
          hk        <= key_rdata;
          hr        <= '0;
          hcnt      <= 6'd0;
          ret       <= lhkc_pkg::ST_U_RD;
        end
        lhkc_pkg::ST_U_WR: begin
          if (prev_rdata[9]) begin
            head <= next_rdata;
          end
          if (next_rdata[9]) begin
            tail <= prev_rdata;
          end
        end
        lhkc_pkg::ST_L_TWO: begin
          if (head[9]) begin
            tail <= {1'b0, id};
          end
          head      <= {1'b0, id};
          pid       <= id;
          h         <= khome;
          new_place <= inserting;
        end
        lhkc_pkg::ST_C_CHK: begin
          if (slot_rdata == 10'd0) begin
            gi <= 10'd0;
          end else begin
            if (s_minus[8:0] != id) begin
              gj <= gj + 10'd1;
            end
            h <= h_inc;
          end
        end
        lhkc_pkg::ST_R_ID: pid <= gat_rdata;
        lhkc_pkg::ST_R_KEY: begin
          hk        <= key_rdata;
          hr        <= '0;
          hcnt      <= 6'd0;
          ret       <= lhkc_pkg::ST_P_RD;
          new_place <= 1'b0;
        end
        lhkc_pkg::ST_P_CHK: begin
          if (slot_rdata == 10'd0) begin
            if (new_place) begin
              count    <= count + 10'd1;
              r_eid    <= pid;
              r_status <= evicting ? lhkc_pkg::STAT_EVICT : lhkc_pkg::STAT_INS;
            end else begin
              gi <= gi + 10'd1;
            end
          end else begin
            h <= h_inc;
          end
        end
        lhkc_pkg::ST_D_END: begin
          if (!freed[9]) begin
            freed <= freed + 10'd1;
          end
          if (count != 10'd0) begin
            count <= count - 10'd1;
          end
        end
        lhkc_pkg::ST_ALLOC: begin
          if (!have_free) begin
            r_ekey <= 64'd0;
            r_evid <= 9'd0;
          end else if (freed != 10'd0) begin
            freed <= freed - 10'd1;
          end else begin
            id    <= fresh[8:0];
            fresh <= fresh + 10'd1;
          end
        end
        lhkc_pkg::ST_A_POP: id <= stk_rdata;
        lhkc_pkg::ST_A_KEY: inserting <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
    end else if (ob_load) begin
      ob_valid <= 1'b1;
    end else if (m_tready) begin
      ob_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ob_load) begin
      ob_data <= {count, r_clr, r_evid, r_ekey, r_eid, r_status};
    end
  end

endmodule
`default_nettype wire

>>> design/lru_hash_key_cache.sv
// Top level of the LRU hash key cache: front queue, back engine and mode register.
// Sequence per word: pop, home slot (nibble by nibble when SLOT_COUNT is not a power of two),
// a read and key compare per occupied probed slot and a read for the empty one, a list update
// on a hit, placement probes on an insert, then the output state; the result is valid the cycle after.
// The back engine takes one word at a time; a drop also scans the cluster and rehashes each survivor
// with a home and a probe. Reset: synchronous rst; a clearing pass over all slots holds s_tready low.
`default_nettype none
module lru_hash_key_cache #(
  parameter int SLOT_COUNT  = lhkc_pkg::DEF_SLOT_COUNT,
  parameter int EVICT_LIMIT = lhkc_pkg::DEF_EVICT_LIMIT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // key[63:0]
  input  wire logic        s_tuser,   // action[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[2:0], entry_id[11:3], evicted_key[75:12], evicted_id[84:76],
  // clear_payload[85], entries_held[95:86]
  output logic [95:0]      m_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata
);

  logic                 no_cache;
  lhkc_pkg::queue_t     q;
  lhkc_pkg::back_stat_t bst;

  always_ff @(posedge clk) begin
    if (rst) begin
      no_cache <= 1'b0;
    end else if (cfg_we) begin
      no_cache <= cfg_wdata;
    end
  end

  lhkc_front u_front (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .bst(bst), .q(q)
  );

  lhkc_back #(.SLOT_COUNT(SLOT_COUNT), .EVICT_LIMIT(EVICT_LIMIT)) u_back (
    .clk(clk), .rst(rst), .q(q), .bst(bst), .no_cache(no_cache),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

`ifndef SYNTHESIS
  a_init_blocks: assert property (@(posedge clk) disable iff (rst)
    !bst.init_done |-> !s_tready) else $error("word accepted during clearing pass");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] == lhkc_pkg::STAT_HIT || m_tdata[2:0] == lhkc_pkg::STAT_INS ||
                  m_tdata[2:0] == lhkc_pkg::STAT_EVICT || m_tdata[2:0] == lhkc_pkg::STAT_REM ||
                  m_tdata[2:0] == lhkc_pkg::STAT_ABSENT)) else $error("bad status");
  a_clear_on_hit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[85] |-> m_tdata[2:0] == lhkc_pkg::STAT_HIT)
    else $error("clear_payload without hit");
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != lhkc_pkg::STAT_EVICT |-> m_tdata[84:12] == 73'd0)
    else $error("eviction fields set without eviction");
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[95:86] <= 10'd512) else $error("entry count overflow");
`endif

endmodule
`default_nettype wire
